// ----- src/sfla_pkg.sv -----
package sfla_pkg;

  // fixed field widths
  localparam int OFS_W     = 26;
  localparam int BYTES_W   = 17;
  localparam int CFG_W     = 11;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * CFG_W;
  localparam int END_W     = PROD_W + 1;

  // default link store depth
  localparam int DEF_TOTAL_SLOTS = 1024;

  // register reset values
  localparam logic [CFG_W-1:0]   RST_SLOTS_PER_BLOCK = CFG_W'(16);
  localparam logic [BYTES_W-1:0] RST_SLOT_BYTES      = BYTES_W'(64);
  localparam logic [CFG_W-1:0]   RST_MAX_BLOCKS      = CFG_W'(64);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS      = 2'd2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ALLOC,
    S_LINK,
    S_POP_RD,
    S_POP_WB,
    S_DIV,
    S_FREE,
    S_FALL,
    S_DONE
  } state_t;

endpackage

// ----- src/sfla_if.sv -----
interface sfla_req_if import sfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [OFS_W-1:0] free_offset;

  modport source (output valid, output op, output free_offset, input ready);
  modport sink (input valid, input op, input free_offset, output ready);
endinterface

interface sfla_rsp_if import sfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] alloc_offset;
  logic             status;
  logic             grew;
  logic [CFG_W-1:0] blocks_in_use;

  modport source (output valid, output alloc_offset, output status, output grew,
                  output blocks_in_use, input ready);
  modport sink (input valid, input alloc_offset, input status, input grew,
                input blocks_in_use, output ready);
endinterface

// ----- src/sfla_divider.sv -----
module sfla_divider import sfla_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [OFS_W-1:0]   dividend,
  input  logic [BYTES_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [OFS_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(OFS_W);

  logic [BYTES_W-1:0] rem;
  logic [BYTES_W-1:0] dvs;
  logic [OFS_W-1:0]   quo;
  logic [STEP_W-1:0]  step;
  logic [BYTES_W:0]   trial;
  logic               fits;

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem, quo[OFS_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(OFS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= BYTES_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[BYTES_W-1:0];
      end
      quo <= {quo[OFS_W-2:0], fits};
    end
  end

  assign quotient = quo;

  // partial remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < dvs) else $error("divider remainder out of range");

  // done follows a busy run
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("divider done without run");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider did not start");

endmodule

// ----- src/slab_free_list_allocator.sv -----
// Slab free-list allocator: hands out fixed-size slots as byte offsets.
// req channel (sink): op 0 allocates, op 1 frees the slot at free_offset,
// op 2 returns every committed slot to the free list. rsp channel (source):
// one transaction per request, with alloc_offset, status, grew and
// blocks_in_use. Config port: cfg_we, cfg_index, cfg_data; write only while idle.
// One request is worked at a time; req.ready is high only in the idle state.
// Work from acceptance to rsp.valid, as done by the sequencer and its units:
//   allocate from a non-empty list: pop the head (link memory read is registered)
//   allocate with growth: link the new block (one link written per cycle), pop
//   allocate refused: straight to the result
//   free: restoring divider (one quotient bit per cycle), then push the slot
//   free all: relink the committed slots (one link written per cycle)
//   unknown op: straight to the result
// The next request is taken the cycle after the result is loaded.
// The result sits in an output register, so a request may be accepted while
// the previous result still waits; a stalled receiver holds the block in its
// final state until the register frees. Reset empties the free list, clears the
// block count and restores register defaults; the link memory is not cleared.
module slab_free_list_allocator import sfla_pkg::*; #(
  parameter int TOTAL_SLOTS = DEF_TOTAL_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0]   cfg_data,
  sfla_req_if.sink             req,
  sfla_rsp_if.source           rsp
);

  localparam int IDX_W  = $clog2(TOTAL_SLOTS);
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] LINK_NULL = '1;
  localparam logic [LINK_W-1:0] TOTAL_L   = LINK_W'(TOTAL_SLOTS);
  localparam logic [PROD_W-1:0] TOTAL_P   = PROD_W'(TOTAL_SLOTS);
  localparam logic [END_W-1:0]  TOTAL_E   = END_W'(TOTAL_SLOTS);

  // configuration registers
  logic [CFG_W-1:0]   spb;
  logic [BYTES_W-1:0] sb;
  logic [CFG_W-1:0]   maxb;

  // sequencer state
  state_t              state, state_next;
  logic [OP_W-1:0]     op_r;
  logic [OFS_W-1:0]    off_r;
  logic [LINK_W-1:0]   head, head_next;
  logic [CFG_W-1:0]    block_count, bc_next;
  logic [PROD_W-1:0]   prev_r, prev_next;
  logic [LINK_W-1:0]   cnt, cnt_next;
  logic [LINK_W-1:0]   last_r, last_next;
  logic [LINK_W-1:0]   first_r, first_next;
  logic                grow_r, grow_next;
  logic [OFS_W-1:0]    res_off, res_off_next;
  logic                status_r, status_next;
  logic                grew_r, grew_next;

  // link memory port
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [LINK_W-1:0]   mem_wdata;
  logic [LINK_W-1:0]   mem_rdata;
  logic [LINK_W-1:0]   next_link [TOTAL_SLOTS];

  // divider
  logic                div_start, div_busy, div_done;
  logic [OFS_W-1:0]    div_quo;

  // derived values
  logic [BYTES_W-1:0]       eff_bytes;
  logic [LINK_W-1:0]        committed;
  logic [END_W-1:0]         grow_end;
  logic                     grow_fail;
  logic                     head_null;
  logic [IDX_W+BYTES_W-1:0] pop_prod;
  logic [LINK_W-1:0]        cnt_inc;
  logic                     out_free;
  logic                     load;

  // output register
  logic               rsp_valid;
  logic [OFS_W-1:0]   out_off;
  logic               out_status;
  logic               out_grew;
  logic [CFG_W-1:0]   out_blocks;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spb  <= RST_SLOTS_PER_BLOCK;
      sb   <= RST_SLOT_BYTES;
      maxb <= RST_MAX_BLOCKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOTS_PER_BLOCK: spb  <= cfg_data[CFG_W-1:0];
        REG_SLOT_BYTES:      sb   <= cfg_data;
        REG_MAX_BLOCKS:      maxb <= cfg_data[CFG_W-1:0];
        default:             ;
      endcase
    end
  end

  assign eff_bytes = (sb == '0) ? BYTES_W'(1) : sb;
  assign committed = (prev_r > TOTAL_P) ? TOTAL_L : LINK_W'(prev_r);
  assign grow_end  = {1'b0, prev_r} + END_W'(spb);
  assign grow_fail = (block_count >= maxb) || (spb == '0) || (grow_end > TOTAL_E);
  assign head_null = head == LINK_NULL;
  assign pop_prod  = head[IDX_W-1:0] * eff_bytes;
  assign cnt_inc   = cnt + LINK_W'(1);
  assign out_free  = !rsp_valid || rsp.ready;
  assign load      = (state == S_DONE) && out_free;

  // link memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_link[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= next_link[head[IDX_W-1:0]];
  end

  sfla_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off_r),
    .divisor  (eff_bytes),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state and datapath control
  always_comb begin
    state_next   = state;
    head_next    = head;
    bc_next      = block_count;
    prev_next    = prev_r;
    cnt_next     = cnt;
    last_next    = last_r;
    first_next   = first_r;
    grow_next    = grow_r;
    res_off_next = res_off;
    status_next  = status_r;
    grew_next    = grew_r;
    mem_we       = 1'b0;
    mem_waddr    = cnt[IDX_W-1:0];
    mem_wdata    = (cnt_inc == last_r) ? LINK_NULL : cnt_inc;
    div_start    = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        prev_next    = block_count * spb;
        res_off_next = '0;
        status_next  = 1'b0;
        grew_next    = 1'b0;
        case (op_r)
          OP_ALLOC:    state_next = S_ALLOC;
          OP_FREE: begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
          OP_FREE_ALL: state_next = S_FALL;
          default:     state_next = S_DONE;
        endcase
      end
      S_ALLOC: begin
        if (!head_null) begin
          state_next = S_POP_RD;
        end else if (grow_fail) begin
          status_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          cnt_next   = LINK_W'(prev_r);
          first_next = LINK_W'(prev_r);
          last_next  = LINK_W'(grow_end);
          grow_next  = 1'b1;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        mem_we   = 1'b1;
        cnt_next = cnt_inc;
        if (cnt_inc == last_r) begin
          head_next = first_r;
          if (grow_r) begin
            bc_next    = block_count + CFG_W'(1);
            grew_next  = 1'b1;
            state_next = S_POP_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_POP_RD: begin
        res_off_next = OFS_W'(pop_prod);
        state_next   = S_POP_WB;
      end
      S_POP_WB: begin
        head_next  = mem_rdata;
        state_next = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        if (div_quo < OFS_W'(committed)) begin
          mem_we    = 1'b1;
          mem_waddr = div_quo[IDX_W-1:0];
          mem_wdata = head;
          head_next = LINK_W'(div_quo);
        end
        state_next = S_DONE;
      end
      S_FALL: begin
        if (committed != '0) begin
          cnt_next   = '0;
          first_next = '0;
          last_next  = committed;
          grow_next  = 1'b0;
          state_next = S_LINK;
        end else begin
          head_next  = LINK_NULL;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= LINK_NULL;
      block_count <= '0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      block_count <= bc_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r  <= req.op;
      off_r <= req.free_offset;
    end
    prev_r   <= prev_next;
    cnt      <= cnt_next;
    last_r   <= last_next;
    first_r  <= first_next;
    grow_r   <= grow_next;
    res_off  <= res_off_next;
    status_r <= status_next;
    grew_r   <= grew_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_off    <= res_off;
      out_status <= status_r;
      out_grew   <= grew_r;
      out_blocks <= block_count;
    end
  end

  assign req.ready         = state == S_IDLE;
  assign rsp.valid         = rsp_valid;
  assign rsp.alloc_offset  = out_off;
  assign rsp.status        = out_status;
  assign rsp.grew          = out_grew;
  assign rsp.blocks_in_use = out_blocks;

  // list head is a real slot or the null marker
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head == LINK_NULL || head < TOTAL_L) else $error("list head out of range");

  // link walk never runs past its end
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK |-> cnt < last_r) else $error("link walk overran");

  // a refused allocate carries no offset and no growth
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status |-> rsp.alloc_offset == '0 && !rsp.grew)
    else $error("failed allocate with payload");

  // an accepted transaction starts the sequencer
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_PREP) else $error("request not started");

  // the divider runs for as long as the sequencer waits on it
  a_div_running: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_busy || div_done) else $error("divider idle during division");

endmodule

// ----- test/slab_alloc_checker.sv -----
module slab_alloc_checker import sfla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0]   cfg_data,
  sfla_req_if                  req,
  sfla_rsp_if                  rsp,
  output int                   fail_count,
  output int                   outstanding,
  output int                   result_count,
  output int                   grow_count,
  output int                   full_count
);

  localparam int SLOTS = DEF_TOTAL_SLOTS;
  localparam logic [CFG_W-1:0] NO_SLOT = '1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic             status;
    logic             grew;
    logic [CFG_W-1:0] blocks;
  } slab_result_t;

  // shadow of the allocator state and its registers
  logic [CFG_W-1:0]   link_mem [SLOTS];
  logic [CFG_W-1:0]   free_head;
  logic [CFG_W-1:0]   blocks;
  logic [CFG_W-1:0]   per_block;
  logic [BYTES_W-1:0] slot_bytes;
  logic [CFG_W-1:0]   block_limit;

  slab_result_t pending_results [$];
  int fails;
  int checked;
  int grown;
  int refused;

  // chain slots first..last-1 in ascending order, last one ends the list
  function automatic void chain_slots(input longint unsigned first, input longint unsigned last);
    longint unsigned i;
    for (i = first; i < last; i++) begin
      link_mem[i] = (i + 1 == last) ? NO_SLOT : CFG_W'(i + 1);
    end
  endfunction

  // apply one request to the shadow state and work out its result
  function automatic slab_result_t next_slab_result(input logic [OP_W-1:0] op,
                                                    input logic [OFS_W-1:0] offset);
    slab_result_t r;
    longint unsigned step_bytes;
    longint unsigned live;
    longint unsigned first;
    longint unsigned last;
    longint unsigned slot;
    r = '0;
    step_bytes = (slot_bytes == '0) ? 64'd1 : 64'(slot_bytes);
    live = 64'(blocks) * 64'(per_block);
    if (live > SLOTS) live = SLOTS;
    case (op)
      OP_ALLOC: begin
        // empty list: commit one more block if the limits allow it
        if (free_head == NO_SLOT) begin
          first = 64'(blocks) * 64'(per_block);
          last = first + 64'(per_block);
          if (blocks < block_limit && per_block != '0 && last <= SLOTS) begin
            chain_slots(first, last);
            free_head = CFG_W'(first);
            blocks = blocks + CFG_W'(1);
            r.grew = 1'b1;
          end
        end
        if (free_head < SLOTS) begin
          slot = 64'(free_head);
          free_head = link_mem[slot];
          r.offset = OFS_W'(slot * step_bytes);
        end else begin
          r.status = 1'b1;
        end
      end
      OP_FREE: begin
        // remainder dropped, out-of-range slots ignored
        slot = 64'(offset) / step_bytes;
        if (slot < live) begin
          link_mem[slot] = free_head;
          free_head = CFG_W'(slot);
        end
      end
      OP_FREE_ALL: begin
        if (live > 0) begin
          chain_slots(0, live);
          free_head = '0;
        end else begin
          free_head = NO_SLOT;
        end
      end
      default: begin
      end
    endcase
    r.blocks = blocks;
    return r;
  endfunction

  always @(posedge clk) begin
    slab_result_t want;
    slab_result_t got;
    if (rst) begin
      free_head = NO_SLOT;
      blocks = '0;
      per_block = RST_SLOTS_PER_BLOCK;
      slot_bytes = RST_SLOT_BYTES;
      block_limit = RST_MAX_BLOCKS;
      pending_results.delete();
      fails = 0;
      checked = 0;
      grown = 0;
      refused = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOTS_PER_BLOCK: per_block = cfg_data[CFG_W-1:0];
          REG_SLOT_BYTES:      slot_bytes = cfg_data;
          REG_MAX_BLOCKS:      block_limit = cfg_data[CFG_W-1:0];
          default: begin
          end
        endcase
      end
      // result transaction against the oldest expectation
      if (rsp.valid && rsp.ready) begin
        got = {rsp.alloc_offset, rsp.status, rsp.grew, rsp.blocks_in_use};
        checked++;
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("unexpected result %0d: offset %h status %0d grew %0d blocks %0d",
                     checked, got.offset, got.status, got.grew, got.blocks);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("result %0d mismatch: expected offset %h status %0d grew %0d blocks %0d",
                       checked, want.offset, want.status, want.grew, want.blocks);
              $display("  got offset %h status %0d grew %0d blocks %0d",
                       got.offset, got.status, got.grew, got.blocks);
            end
          end
        end
      end
      // request transaction: predict what it returns
      if (req.valid && req.ready) begin
        want = next_slab_result(req.op, req.free_offset);
        if (want.grew) grown++;
        if (want.status) refused++;
        pending_results.push_back(want);
      end
    end
    fail_count <= fails;
    outstanding <= pending_results.size();
    result_count <= checked;
    grow_count <= grown;
    full_count <= refused;
  end

endmodule

// ----- test/slab_free_list_allocator_test.sv -----
module slab_free_list_allocator_test;
  import sfla_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTES_W-1:0]   cfg_data;

  sfla_req_if req_ch ();
  sfla_rsp_if rsp_ch ();

  int fail_count;
  int outstanding;
  int result_count;
  int grow_count;
  int full_count;

  // stimulus controls
  int gap_pct;
  int stall_pct;
  int free_all_pct;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int cur_bytes;
  int sent;
  int settings;
  int idle_cycles;
  logic [OP_W-1:0]  sent_ops [$];
  logic [OFS_W-1:0] live_offsets [$];

  slab_free_list_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  slab_alloc_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .result_count (result_count),
    .grow_count   (grow_count),
    .full_count   (full_count)
  );

  always #10 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // keep offsets handed out by successful allocations for later frees
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && sent_ops.size() != 0) begin
      if (sent_ops.pop_front() == OP_ALLOC && rsp_ch.status == 1'b0) begin
        live_offsets.push_back(rsp_ch.alloc_offset);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("** slab_free_list_allocator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one request and wait for its transaction
  task automatic send(input logic [OP_W-1:0] op, input logic [OFS_W-1:0] offset);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.free_offset <= offset;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_ops.push_back(op);
    sent++;
  endtask

  // wait until every result is in and the block takes requests again
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || !req_ch.ready);
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] per_block,
                               input logic [BYTES_W-1:0] bytes,
                               input logic [CFG_W-1:0] most_blocks);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_SLOTS_PER_BLOCK;
    cfg_data <= BYTES_W'(per_block);
    @(posedge clk);
    cfg_index <= REG_SLOT_BYTES;
    cfg_data <= bytes;
    @(posedge clk);
    cfg_index <= REG_MAX_BLOCKS;
    cfg_data <= BYTES_W'(most_blocks);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_bytes = (bytes == '0) ? 1 : int'(bytes);
    live_offsets.delete();
    settings++;
  endtask

  // mostly allocations and frees of live offsets, some noise
  task automatic random_item();
    int pick;
    int k;
    logic [OFS_W-1:0] offset;
    pick = $urandom_range(99);
    offset = OFS_W'($urandom);
    if (pick < free_all_pct) begin
      live_offsets.delete();
      send(OP_FREE_ALL, offset);
    end else if (pick < free_all_pct + 4) begin
      send(OP_UNKNOWN, offset);
    end else if (pick < 56) begin
      send(OP_ALLOC, offset);
    end else begin
      pick = $urandom_range(99);
      if (live_offsets.size() != 0 && pick < 75) begin
        k = $urandom_range(live_offsets.size() - 1);
        offset = live_offsets[k];
        // now and then leave it in the pool so it gets freed twice
        if ($urandom_range(9) != 0) live_offsets.delete(k);
      end else if (pick < 92) begin
        offset = OFS_W'(longint'($urandom_range(1100)) * cur_bytes
                        + $urandom_range(cur_bytes - 1));
      end
      send(OP_FREE, offset);
    end
  endtask

  task automatic random_phase(input int items, input int gap, input int stall,
                              input int all_pct, input bit pressure);
    int n;
    gap_pct = gap;
    stall_pct <= stall;
    free_all_pct = all_pct;
    for (n = 0; n < items; n++) begin
      if (pressure && n == items / 4) hold_asks <= hold_asks + 1;
      random_item();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SLOTS_PER_BLOCK;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.free_offset = '0;
    gap_pct = 0;
    stall_pct = 0;
    free_all_pct = 0;
    hold_asks = 0;
    cur_bytes = int'(RST_SLOT_BYTES);
    sent = 0;
    settings = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // widest block, largest slot: growth by a full store, double free, free-all
    set_registers(11'd1024, 17'h1FFFF, 11'd1024);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '1);
    send(OP_FREE, '1);
    send(OP_ALLOC, '0);
    send(OP_FREE, '0);
    send(OP_FREE, '0);
    send(OP_ALLOC, '0);
    send(OP_ALLOC, '0);
    send(OP_UNKNOWN, '1);
    send(OP_FREE_ALL, '0);

    // zero registers: frees ignored, empty free-all, growth refused
    set_registers('0, '0, '0);
    send(OP_FREE, OFS_W'(3));
    send(OP_FREE_ALL, '1);
    send(OP_ALLOC, '0);
    send(OP_UNKNOWN, '0);

    // default registers: growth after a change, unaligned and out-of-range frees
    set_registers(RST_SLOTS_PER_BLOCK, RST_SLOT_BYTES, RST_MAX_BLOCKS);
    send(OP_ALLOC, '0);
    send(OP_FREE, OFS_W'(16 * 64 + 63));
    send(OP_ALLOC, '0);
    send(OP_FREE, '1);
    send(OP_ALLOC, '0);
    send(OP_FREE_ALL, '0);
    send(OP_ALLOC, '0);

    // random phases over several register settings and idling patterns
    random_phase(80, 0, 0, 2, 1'b1);
    set_registers(11'd1, 17'd4, 11'd1);
    random_phase(60, 55, 0, 2, 1'b0);
    set_registers(11'd5, 17'd24, 11'd2047);
    random_phase(90, 0, 55, 2, 1'b0);
    set_registers(11'd2047, 17'h1FFFF, 11'd1024);
    random_phase(60, 7, 7, 12, 1'b0);
    set_registers(11'd3, 17'd1000, 11'd400);
    random_phase(80, 0, 0, 3, 1'b0);
    set_registers(11'd1024, 17'd65536, 11'd1);
    random_phase(80, 0, 55, 3, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests over %0d register settings, %0d results checked",
             sent, settings, result_count);
    $display("%0d allocations grew the slab, %0d found no space", grow_count, full_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** slab_free_list_allocator: PASSED **");
    end else begin
      $display("** slab_free_list_allocator: FAILED **");
    end
    $finish;
  end

endmodule
